[sv/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// itaf_pkg
// types, codes and character constants shared by the formatter modules
// ----------------------------------------------------------------------------
`default_nettype none

package itaf_pkg;

	localparam int VAL_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;

	localparam logic [1:0] CMD_UDEC = 2'd0;
	localparam logic [1:0] CMD_SDEC = 2'd1;
	localparam logic [1:0] CMD_HEX  = 2'd2;
	localparam logic [1:0] CMD_NL   = 2'd3;

	localparam logic [4:0] CONV_LAST = 5'(VAL_W - 1);

	localparam logic [3:0] LEN_HEX = 4'd10;
	localparam logic [3:0] LEN_NL  = 4'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_A     = 8'h41;

	typedef struct packed {
		logic load;
		logic shift;
		logic find;
		logic emit;
	} itaf_cmd_t;

	typedef struct packed {
		logic emit_last;
	} itaf_sts_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else begin
			c = CH_A + {4'd0, nib - 4'd10};
		end
		return c;
	endfunction

	function automatic logic [7:0] dec_char(input logic [3:0] d);
		return CH_ZERO | {4'd0, d};
	endfunction

endpackage

`default_nettype wire

[sv/itaf_ctrl.sv]
// ----------------------------------------------------------------------------
// itaf_ctrl
// controller: sequences load, binary to bcd conversion, digit count and output
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [1:0]          command,
	output logic                out_valid,
	input  wire                 out_stall,
	output itaf_pkg::itaf_cmd_t cmd,
	input  itaf_pkg::itaf_sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_FIND = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       is_dec;

	assign is_dec    = (command == itaf_pkg::CMD_UDEC) || (command == itaf_pkg::CMD_SDEC);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.shift = (state_q == S_CONV);
		cmd.find  = (state_q == S_FIND);
		cmd.emit  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= itaf_pkg::CONV_LAST;
						state_q <= is_dec ? S_CONV : S_EMIT;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cmd.emit && sts.emit_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && cnt_q == 5'd0) |=> (state_q == S_FIND))
		else $error("conversion did not end after the last shift");

	a_hex_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !is_dec) |=> (state_q == S_EMIT))
		else $error("hex or newline word did not go straight to output");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.emit_last) |=> (state_q == S_IDLE && out_valid_q))
		else $error("final character did not return controller to idle");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (state_q == S_EMIT))
		else $error("character written outside output phase");

endmodule

`default_nettype wire

[sv/itaf_dpath.sv]
// ----------------------------------------------------------------------------
// itaf_dpath
// datapath: magnitude, shift-and-add-3 bcd converter, digit count, char mux
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_dpath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [1:0]          command,
	input  wire  [31:0]         value,
	input  itaf_pkg::itaf_cmd_t cmd,
	output itaf_pkg::itaf_sts_t sts,
	output logic [7:0]          char_code,
	output logic                last
);

	logic [1:0]                   cmd_q;
	logic [itaf_pkg::VAL_W-1:0]   val_q;
	logic [itaf_pkg::BCD_W-1:0]   bcd_q;
	logic                         neg_q;
	logic [3:0]                   nd_q;
	logic [3:0]                   n_q;
	logic [3:0]                   ch_q;
	logic [7:0]                   char_q;
	logic                         last_q;

	logic                         neg_in;
	logic [itaf_pkg::VAL_W-1:0]   mag_in;
	logic [itaf_pkg::BCD_W-1:0]   bcd_adj;
	logic [3:0]                   nd_calc;
	logic [3:0]                   pos;
	logic [3:0]                   di;
	logic [3:0]                   dig;
	logic [2:0]                   hidx;
	logic [3:0]                   nib;
	logic [7:0]                   next_char;

	assign neg_in = (command == itaf_pkg::CMD_SDEC) && value[31];
	assign mag_in = neg_in ? (~value + 32'd1) : value;

	always_comb begin
		for (int i = 0; i < itaf_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// highest non-zero digit sets the digit count, zero still prints one digit
	always_comb begin
		nd_calc = 4'd1;
		for (int i = 0; i < itaf_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				nd_calc = 4'(i + 1);
			end
		end
	end

	assign pos  = ch_q - {3'd0, neg_q};
	assign di   = nd_q - 4'd1 - pos;
	assign dig  = 4'(bcd_q >> {di, 2'b00});
	assign hidx = 3'(ch_q - 4'd2);
	assign nib  = 4'(val_q >> {3'd7 - hidx, 2'b00});

	always_comb begin
		case (cmd_q)
			itaf_pkg::CMD_UDEC, itaf_pkg::CMD_SDEC: begin
				if (neg_q && ch_q == 4'd0) begin
					next_char = itaf_pkg::CH_MINUS;
				end else begin
					next_char = itaf_pkg::dec_char(dig);
				end
			end
			itaf_pkg::CMD_HEX: begin
				if (ch_q == 4'd0) begin
					next_char = itaf_pkg::CH_ZERO;
				end else if (ch_q == 4'd1) begin
					next_char = itaf_pkg::CH_X;
				end else begin
					next_char = itaf_pkg::hex_char(nib);
				end
			end
			default: begin
				next_char = (ch_q == 4'd0) ? itaf_pkg::CH_CR : itaf_pkg::CH_LF;
			end
		endcase
	end

	assign sts.emit_last = (ch_q == n_q - 4'd1);
	assign char_code     = char_q;
	assign last          = last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			neg_q <= neg_in;
			val_q <= (command == itaf_pkg::CMD_HEX) ? value : mag_in;
			bcd_q <= '0;
			ch_q  <= '0;
			n_q   <= (command == itaf_pkg::CMD_HEX) ? itaf_pkg::LEN_HEX : itaf_pkg::LEN_NL;
		end
		if (cmd.shift) begin
			bcd_q <= {bcd_adj[itaf_pkg::BCD_W-2:0], val_q[itaf_pkg::VAL_W-1]};
			val_q <= {val_q[itaf_pkg::VAL_W-2:0], 1'b0};
		end
		if (cmd.find) begin
			nd_q <= nd_calc;
			n_q  <= nd_calc + {3'd0, neg_q};
		end
		if (cmd.emit) begin
			char_q <= next_char;
			last_q <= sts.emit_last;
			ch_q   <= ch_q + 4'd1;
		end
	end

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find |=> (nd_q >= 4'd1 && nd_q <= 4'(itaf_pkg::BCD_DIGITS)))
		else $error("digit count out of range");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (ch_q < n_q))
		else $error("character index ran past word length");

endmodule

`default_nettype wire

[sv/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// formats a 32-bit value as ascii text, one character per output word
// ----------------------------------------------------------------------------
// Each input word is taken only when the block is idle. Unsigned and signed
// decimal words run through a bit-serial shift-and-add-3 bcd converter, then
// the digits are counted, then n characters go out at one per cycle unless
// out_stall holds the output. Hex and newline words skip the conversion, as
// none is needed. The output register lets the next word be taken while the
// final character still waits downstream.
`default_nettype none

module integer_to_ascii_formatter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  command,
	input  wire  [31:0] value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  char_code,
	output logic        last
);

	itaf_pkg::itaf_cmd_t cmd;
	itaf_pkg::itaf_sts_t sts;

	itaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	itaf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.char_code (char_code),
		.last      (last)
	);

endmodule

`default_nettype wire
